[rtl/fpa_pkg.sv]
// Shared types, codes and helper functions for the fixed-point ALU.
`default_nettype none
package fpa_pkg;

   // Operation codes carried in the request word.
   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_GT       = 4'd4,
      OP_LT       = 4'd5,
      OP_GE       = 4'd6,
      OP_LE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_INC      = 4'd12,
      OP_DEC      = 4'd13,
      OP_FROM_INT = 4'd14,
      OP_TO_INT   = 4'd15
   } op_type;

   // Status codes of a result word.
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_OVF  = 2'd1;
   localparam logic [1:0] STATUS_DIV0 = 2'd2;

   // Number of quotient bits developed by the divider, one per stage.
   localparam int DIV_STEPS = 32;

   localparam logic signed [63:0] MAX_VALUE = 64'sd2147483647;
   localparam logic signed [63:0] MIN_VALUE = -64'sd2147483648;

   typedef struct packed {
      logic [3:0]         operation;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               truth;
      logic [1:0]         status;
   } rsp_type;

   // Partial state of one restoring division.
   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] divisor;
      logic [31:0] low;
      logic [31:0] quo;
   } div_type;

   // Everything that rides alongside the divider.
   typedef struct packed {
      op_type             op;
      rsp_type            fast;
      logic signed [63:0] product;
      logic               div_neg;
      logic               div_ovf;
      logic               div_zero;
   } side_type;

   // Clamp a wide signed value to the 32-bit range and flag saturation.
   function automatic rsp_type clamp64(input logic signed [63:0] v);
      rsp_type r;
      r.truth  = 1'b0;
      r.status = STATUS_OK;
      r.result_value = v[31:0];
      if (v > MAX_VALUE) begin
         r.result_value = MAX_VALUE[31:0];
         r.status = STATUS_OVF;
      end else if (v < MIN_VALUE) begin
         r.result_value = MIN_VALUE[31:0];
         r.status = STATUS_OVF;
      end
      return r;
   endfunction

   // One restoring division step: bring down a dividend bit, try a subtract.
   function automatic div_type div_step(input div_type d);
      div_type     r;
      logic [32:0] t;
      t = {d.rem, d.low[31]};
      r = d;
      r.low = {d.low[30:0], 1'b0};
      if (t >= {1'b0, d.divisor}) begin
         t = t - {1'b0, d.divisor};
         r.quo = {d.quo[30:0], 1'b1};
      end else begin
         r.quo = {d.quo[30:0], 1'b0};
      end
      r.rem = t[31:0];
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/fpa_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module fpa_div_pipe (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 advance,
   input  wire                 in_valid,
   input  fpa_pkg::div_type    in_div,
   input  fpa_pkg::side_type   in_side,
   output logic                out_valid,
   output fpa_pkg::div_type    out_div,
   output fpa_pkg::side_type   out_side
);

   logic              valid_ff [fpa_pkg::DIV_STEPS];
   fpa_pkg::div_type  div_ff   [fpa_pkg::DIV_STEPS];
   fpa_pkg::side_type side_ff  [fpa_pkg::DIV_STEPS];
   fpa_pkg::div_type  div_in   [fpa_pkg::DIV_STEPS];

   // Each stage takes the previous stage's partial division one step further.
   always_comb begin
      div_in[0] = fpa_pkg::div_step(in_div);
      for (int i = 1; i < fpa_pkg::DIV_STEPS; i++) begin
         div_in[i] = fpa_pkg::div_step(div_ff[i-1]);
      end
   end

   // Valid bits move with the data; the whole pipe holds while stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fpa_pkg::DIV_STEPS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < fpa_pkg::DIV_STEPS; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff[0]  <= div_in[0];
         side_ff[0] <= in_side;
         for (int i = 1; i < fpa_pkg::DIV_STEPS; i++) begin
            div_ff[i]  <= div_in[i];
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[fpa_pkg::DIV_STEPS-1];
   assign out_div   = div_ff[fpa_pkg::DIV_STEPS-1];
   assign out_side  = side_ff[fpa_pkg::DIV_STEPS-1];

endmodule
`default_nettype wire

[rtl/fixed_point_alu_core.sv]
// Top level of the pipelined signed fixed-point ALU.
// Throughput: one word per cycle unless the response word is stalled; the 32-stage
// divider pipe sets the depth. All stages advance together and hold while the
// response word is stalled.
// Reset clears only the valid bits; no word is in flight after reset.
`default_nettype none
module fixed_point_alu_core #(
   parameter int FRAC_BITS = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  fpa_pkg::req_type  req_word,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output fpa_pkg::rsp_type  rsp_word
);

   localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

   logic              advance;
   logic              s1_valid_ff;
   fpa_pkg::req_type  s1_ff;
   logic              s2_valid_ff;
   fpa_pkg::side_type s2_side_ff;
   fpa_pkg::side_type s2_side_in;
   fpa_pkg::div_type  s2_div_ff;
   fpa_pkg::div_type  s2_div_in;
   logic              dp_valid;
   fpa_pkg::div_type  dp_div;
   fpa_pkg::side_type dp_side;
   logic              out_valid_ff;
   fpa_pkg::rsp_type  out_ff;
   fpa_pkg::rsp_type  out_in;

   // The pipe moves whenever the output register is free or being taken.
   assign advance   = !(out_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // First stage: register the request word.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= req_word;
      end
   end

   // Second stage: cheap operations, the product and the divider set-up.
   always_comb begin
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic [63:0]        mag_a;
      logic [63:0]        mag_b;
      logic [63:0]        shifted_a;
      a = 64'(s1_ff.operand_a);
      b = 64'(s1_ff.operand_b);
      mag_a = (a < 0) ? 64'(-a) : 64'(a);
      mag_b = (b < 0) ? 64'(-b) : 64'(b);
      shifted_a = mag_a << FRAC_BITS;

      s2_side_in.op       = fpa_pkg::op_type'(s1_ff.operation);
      s2_side_in.product  = a * b;
      s2_side_in.div_neg  = (a < 0) != (b < 0);
      s2_side_in.div_zero = (b == 0);
      s2_side_in.div_ovf  = shifted_a >= (mag_b << 32);

      s2_div_in.rem     = shifted_a[63:32];
      s2_div_in.low     = shifted_a[31:0];
      s2_div_in.divisor = mag_b[31:0];
      s2_div_in.quo     = '0;

      s2_side_in.fast.result_value = '0;
      s2_side_in.fast.truth        = 1'b0;
      s2_side_in.fast.status       = fpa_pkg::STATUS_OK;
      case (fpa_pkg::op_type'(s1_ff.operation))
         fpa_pkg::OP_ADD:      s2_side_in.fast = fpa_pkg::clamp64(a + b);
         fpa_pkg::OP_SUB:      s2_side_in.fast = fpa_pkg::clamp64(a - b);
         fpa_pkg::OP_GT:       s2_side_in.fast.truth = (a > b);
         fpa_pkg::OP_LT:       s2_side_in.fast.truth = (a < b);
         fpa_pkg::OP_GE:       s2_side_in.fast.truth = (a >= b);
         fpa_pkg::OP_LE:       s2_side_in.fast.truth = (a <= b);
         fpa_pkg::OP_EQ:       s2_side_in.fast.truth = (a == b);
         fpa_pkg::OP_NE:       s2_side_in.fast.truth = (a != b);
         fpa_pkg::OP_MIN:      s2_side_in.fast.result_value = (a > b) ? b[31:0] : a[31:0];
         fpa_pkg::OP_MAX:      s2_side_in.fast.result_value = (a > b) ? a[31:0] : b[31:0];
         fpa_pkg::OP_INC:      s2_side_in.fast = fpa_pkg::clamp64(a + 64'sd1);
         fpa_pkg::OP_DEC:      s2_side_in.fast = fpa_pkg::clamp64(a - 64'sd1);
         fpa_pkg::OP_FROM_INT: s2_side_in.fast = fpa_pkg::clamp64(a <<< FRAC_BITS);
         fpa_pkg::OP_TO_INT:   s2_side_in.fast.result_value = s1_ff.operand_a >>> FRAC_BITS;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_side_ff <= s2_side_in;
         s2_div_ff  <= s2_div_in;
      end
   end

   // Divider pipe; the other results ride along beside it.
   fpa_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s2_valid_ff),
      .in_div    (s2_div_ff),
      .in_side   (s2_side_ff),
      .out_valid (dp_valid),
      .out_div   (dp_div),
      .out_side  (dp_side)
   );

   // Final stage: round the product and the quotient, then pick the result.
   always_comb begin
      logic              mul_neg;
      logic [63:0]       mul_mag;
      logic [63:0]       mul_q;
      logic [32:0]       div_q;
      logic [63:0]       div_q64;
      mul_neg = dp_side.product < 0;
      mul_mag = mul_neg ? 64'(-dp_side.product) : 64'(dp_side.product);
      mul_q   = (mul_mag + HALF) >> FRAC_BITS;
      div_q   = {1'b0, dp_div.quo} +
                33'(({1'b0, dp_div.rem, 1'b0} >= {2'b00, dp_div.divisor}) ? 1 : 0);
      div_q64 = 64'(div_q);

      case (dp_side.op)
         fpa_pkg::OP_MUL: begin
            out_in = fpa_pkg::clamp64(mul_neg ? -$signed(mul_q) : $signed(mul_q));
         end
         fpa_pkg::OP_DIV: begin
            if (dp_side.div_zero) begin
               out_in.result_value = '0;
               out_in.truth        = 1'b0;
               out_in.status       = fpa_pkg::STATUS_DIV0;
            end else if (dp_side.div_ovf) begin
               out_in.result_value = dp_side.div_neg ? fpa_pkg::MIN_VALUE[31:0]
                                                     : fpa_pkg::MAX_VALUE[31:0];
               out_in.truth        = 1'b0;
               out_in.status       = fpa_pkg::STATUS_OVF;
            end else begin
               out_in = fpa_pkg::clamp64(dp_side.div_neg ? -$signed(div_q64)
                                                         : $signed(div_q64));
            end
         end
         default: out_in = dp_side.fast;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dp_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   // A divide-by-zero word carries a zero value and no truth bit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == fpa_pkg::STATUS_DIV0 |->
         rsp_word.result_value == 0 && !rsp_word.truth)
      else $error("divide-by-zero word with non-zero payload");

   // A true comparison never carries a value or an error status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.truth |->
         rsp_word.result_value == 0 && rsp_word.status == fpa_pkg::STATUS_OK)
      else $error("truth bit set on a non-comparison word");

   // The request side is held exactly when the output word is stalled.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the pipelined fixed-point ALU core.
`default_nettype none
module tb;

   localparam int FRAC = 8;
   localparam int LATENCY = 35;

   // Scoreboard: predicts each result word and checks words in order.
   class alu_scoreboard;
      fpa_pkg::rsp_type pending[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      // Saturate a wide value into a result word.
      function fpa_pkg::rsp_type saturate(input logic signed [95:0] v);
         fpa_pkg::rsp_type r;
         r.truth = 1'b0;
         r.status = fpa_pkg::STATUS_OK;
         r.result_value = v[31:0];
         if (v > 96'sd2147483647) begin
            r.result_value = 32'sh7fffffff;
            r.status = fpa_pkg::STATUS_OVF;
         end else if (v < -96'sd2147483648) begin
            r.result_value = 32'sh80000000;
            r.status = fpa_pkg::STATUS_OVF;
         end
         return r;
      endfunction

      function fpa_pkg::rsp_type compute(input fpa_pkg::req_type q);
         logic signed [95:0] a, b, p, num;
         logic [95:0] mag, den, quo;
         fpa_pkg::rsp_type r;
         logic neg;
         a = q.operand_a;
         b = q.operand_b;
         r = '0;
         case (fpa_pkg::op_type'(q.operation))
            fpa_pkg::OP_ADD: r = saturate(a + b);
            fpa_pkg::OP_SUB: r = saturate(a - b);
            fpa_pkg::OP_MUL: begin
               p = a * b;
               neg = p < 0;
               mag = neg ? -p : p;
               quo = (mag + (96'd1 << (FRAC - 1))) >> FRAC;
               r = saturate(neg ? -$signed(quo) : $signed(quo));
            end
            fpa_pkg::OP_DIV: begin
               if (b == 0) begin
                  r.status = fpa_pkg::STATUS_DIV0;
               end else begin
                  neg = (a < 0) != (b < 0);
                  num = (a < 0) ? -a : a;
                  mag = num << FRAC;
                  den = (b < 0) ? -b : b;
                  quo = (2 * mag + den) / (2 * den);
                  r = saturate(neg ? -$signed(quo) : $signed(quo));
               end
            end
            fpa_pkg::OP_GT: r.truth = a > b;
            fpa_pkg::OP_LT: r.truth = a < b;
            fpa_pkg::OP_GE: r.truth = a >= b;
            fpa_pkg::OP_LE: r.truth = a <= b;
            fpa_pkg::OP_EQ: r.truth = a == b;
            fpa_pkg::OP_NE: r.truth = a != b;
            fpa_pkg::OP_MIN: r.result_value = (a > b) ? b[31:0] : a[31:0];
            fpa_pkg::OP_MAX: r.result_value = (a > b) ? a[31:0] : b[31:0];
            fpa_pkg::OP_INC: r = saturate(a + 1);
            fpa_pkg::OP_DEC: r = saturate(a - 1);
            fpa_pkg::OP_FROM_INT: r = saturate(a * (96'sd1 <<< FRAC));
            fpa_pkg::OP_TO_INT: r.result_value = q.operand_a >>> FRAC;
            default: r = '0;
         endcase
         return r;
      endfunction

      function void note_request(input fpa_pkg::req_type q);
         pending.push_back(compute(q));
      endfunction

      // Returns a text describing a mismatch, or an empty string.
      function string check_response(input fpa_pkg::rsp_type got);
         fpa_pkg::rsp_type want;
         string s;
         s = "";
         if (pending.size() == 0) return "result word with no expectation";
         want = pending.pop_front();
         if (got.result_value !== want.result_value)
            s = $sformatf("value %h expected %h", got.result_value, want.result_value);
         if (got.truth !== want.truth)
            s = {s, $sformatf(" truth %b expected %b", got.truth, want.truth)};
         if (got.status !== want.status)
            s = {s, $sformatf(" status %0d expected %0d", got.status, want.status)};
         return s;
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, rsp_stall;
   logic req_stall, rsp_valid;
   fpa_pkg::req_type req_word;
   fpa_pkg::rsp_type rsp_word;
   int send_idle_pct, stall_pct;
   int fail_count;
   alu_scoreboard board;

   fixed_point_alu_core #(.FRAC_BITS(FRAC)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_count++;
   endtask

   // Sample both channels at the rising edge.
   always @(posedge clock) begin
      string msg;
      if (!reset) begin
         if (req_valid && !req_stall) board.note_request(req_word);
         if (rsp_valid && !rsp_stall) begin
            msg = board.check_response(rsp_word);
            if (msg != "") report(msg);
         end
      end
   end

   // Receiver stalls at random on each falling edge.
   always @(negedge clock)
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);

   // Offer one word, idling first at random, and hold it until taken.
   // The valid line stays high after the word so that the next word can follow at once.
   task automatic send_word(input fpa_pkg::req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(5))
         0: return 32'h7fffffff - $urandom_range(3);
         1: return 32'h80000000 + $urandom_range(3);
         2: return $urandom_range(2047) - 1024;
         3: return $urandom_range(3) - 1;
         default: return $urandom();
      endcase
   endfunction

   task automatic send(input fpa_pkg::op_type op, input logic [31:0] a,
                       input logic [31:0] b);
      fpa_pkg::req_type q;
      q.operation = op;
      q.operand_a = a;
      q.operand_b = b;
      send_word(q);
   endtask

   initial begin
      int phase;
      fpa_pkg::op_type op;
      fail_count = 0;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // Directed part: extremes, every operation, divide by zero, rounding halves.
      for (int k = 0; k < 16; k++)
         send(fpa_pkg::op_type'(k), 32'h7fffffff, 32'h80000000);
      send(fpa_pkg::OP_DIV, 32'h00000100, 32'h0);
      send(fpa_pkg::OP_DIV, 32'h80000000, 32'hffffffff);
      send(fpa_pkg::OP_MUL, 32'h00000001, 32'h00000080);
      send(fpa_pkg::OP_MUL, 32'hffffffff, 32'h00000080);
      send(fpa_pkg::OP_DIV, 32'h00000001, 32'h00000200);
      send(fpa_pkg::OP_INC, 32'h7fffffff, 32'h0);
      send(fpa_pkg::OP_DEC, 32'h80000000, 32'h0);
      send(fpa_pkg::OP_TO_INT, 32'hffffff01, 32'h0);
      send(fpa_pkg::OP_FROM_INT, 32'hff800000, 32'h0);
      send(fpa_pkg::OP_EQ, 32'h5, 32'h5);
      // Random part across phases of idling and stalling.
      for (int n = 0; n < 700; n++) begin
         phase = n / 175;
         case (phase)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 73; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 73; end
            3: begin send_idle_pct = 33; stall_pct = 33; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         op = fpa_pkg::op_type'($urandom_range(15));
         send(op, rand_operand(), ($urandom_range(9) == 0) ? 32'h0 : rand_operand());
      end
      req_valid <= 1'b0;
      stall_pct = 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (fail_count == 0 && board.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire
